@@ rtl/core/md5s_pkg.sv @@
// ----------------------------------------------------------------------------
// md5s_pkg
// Shared types, constants and round tables for the byte-serial MD5 engine.
// ----------------------------------------------------------------------------
package md5s_pkg;

   // Block queue geometry: two block slots of sixteen 32-bit words
   localparam int unsigned QUEUE_SLOTS     = 2;
   localparam int unsigned WORDS_PER_BLOCK = 16;
   localparam int unsigned RAM_DEPTH       = QUEUE_SLOTS * WORDS_PER_BLOCK;
   localparam int unsigned RAM_ADDR_W      = $clog2(RAM_DEPTH);

   // Word positions of the 64-bit length in the final block, plus last word, last byte, pad byte and last round
   localparam logic [3:0] LEN_WORD_LO  = 4'd14;
   localparam logic [3:0] LEN_WORD_HI  = 4'd15;
   localparam logic [3:0] LAST_WORD    = 4'd15;
   localparam logic [1:0] LAST_BYTE    = 2'd3;
   localparam logic [7:0] PAD_BYTE     = 8'h80;
   localparam logic [5:0] LAST_ROUND   = 6'd63;

   // Standard initial chaining words A, B, C, D
   localparam logic [31:0] INIT_CV [4] = '{
      32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
   };

   // Per-round additive constants
   localparam logic [31:0] ROUND_K [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
   };

   // Rotate amounts, indexed by {round group, round[1:0]}
   localparam logic [4:0] ROT_AMT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22,
      5'd5, 5'd9,  5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23,
      5'd6, 5'd10, 5'd15, 5'd21
   };

   // Front to back: head of the block queue
   typedef struct packed {
      logic avail;
      logic slot;
      logic last_blk;
   } blk_desc_type;

   // Back to front: head block consumed
   typedef struct packed {
      logic done;
   } blk_ack_type;

   // Word write into the block RAM
   typedef struct packed {
      logic                  en;
      logic [RAM_ADDR_W-1:0] addr;
      logic [31:0]           data;
   } mem_wr_type;

   // Message word used by a given round
   function automatic logic [3:0] msg_index(input logic [5:0] rnd);
      logic [3:0] idx;
      case (rnd[5:4])
         2'd0: idx = rnd[3:0];
         2'd1: idx = 4'(rnd[3:0] * 4'd5 + 4'd1);
         2'd2: idx = 4'(rnd[3:0] * 4'd3 + 4'd5);
         2'd3: idx = 4'(rnd[3:0] * 4'd7);
         default: idx = rnd[3:0];
      endcase
      return idx;
   endfunction

endpackage

@@ rtl/core/md5s_ifs.sv @@
// ----------------------------------------------------------------------------
// md5s channel interfaces
// Valid/ready channels for message bytes in and digests out.
// ----------------------------------------------------------------------------

// Message byte channel
interface md5s_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       last;

   modport source (output valid, output data_byte, output byte_valid, output last,
                   input ready);
   modport sink   (input valid, input data_byte, input byte_valid, input last,
                   output ready);
endinterface

// Digest channel
interface md5s_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word0;
   logic [31:0] digest_word1;
   logic [31:0] digest_word2;
   logic [31:0] digest_word3;

   modport source (output valid, output digest_word0, output digest_word1,
                   output digest_word2, output digest_word3, input ready);
   modport sink   (input valid, input digest_word0, input digest_word1,
                   input digest_word2, input digest_word3, output ready);
endinterface

@@ rtl/core/md5s_ram.sv @@
// ----------------------------------------------------------------------------
// md5s_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module md5s_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ rtl/core/md5s_front.sv @@
// ----------------------------------------------------------------------------
// md5s_front
// Packs message bytes into words, writes blocks into the block RAM, appends
// padding and length, and keeps the two-slot block queue bookkeeping.
// ----------------------------------------------------------------------------
module md5s_front (
   input  logic                     clock,
   input  logic                     reset,
   md5s_req_if.sink                 req_ch,
   input  md5s_pkg::blk_ack_type    ack,
   output md5s_pkg::blk_desc_type   desc,
   output md5s_pkg::mem_wr_type     wr
);
   import md5s_pkg::*;

   localparam logic [2:0] ST_BYTES  = 3'd0;
   localparam logic [2:0] ST_PAD    = 3'd1;
   localparam logic [2:0] ST_ZERO   = 3'd2;
   localparam logic [2:0] ST_LEN_LO = 3'd3;
   localparam logic [2:0] ST_LEN_HI = 3'd4;

   localparam logic [1:0] SLOTS = 2'(QUEUE_SLOTS);

   logic [2:0]  state_ff, state_in;
   logic [31:0] word_ff, word_in;
   logic [1:0]  byte_pos_ff, byte_pos_in;
   logic [3:0]  word_idx_ff, word_idx_in;
   logic [63:0] bit_len_ff, bit_len_in;
   logic        wr_slot_ff, wr_slot_in;
   logic        rd_slot_ff, rd_slot_in;
   logic [1:0]  count_ff, count_in;
   logic [1:0]  final_ff, final_in;

   logic        slot_free;
   logic        accept;
   logic        push;
   logic        push_final;
   logic [31:0] merged;

   assign slot_free    = (count_ff < SLOTS);
   assign req_ch.ready = (state_ff == ST_BYTES) && slot_free;
   assign accept       = req_ch.valid && req_ch.ready;

   // Head of the queue to the back end
   assign desc.avail    = (count_ff != 2'd0);
   assign desc.slot     = rd_slot_ff;
   assign desc.last_blk = final_ff[rd_slot_ff];

   // Byte packing, padding sequence and queue push
   always_comb begin
      state_in    = state_ff;
      word_in     = word_ff;
      byte_pos_in = byte_pos_ff;
      word_idx_in = word_idx_ff;
      bit_len_in  = bit_len_ff;
      push        = 1'b0;
      push_final  = 1'b0;
      merged      = word_ff;
      wr.en       = 1'b0;
      wr.addr     = {wr_slot_ff, word_idx_ff};
      wr.data     = word_ff;

      case (state_ff)
         ST_BYTES: begin
            if (accept) begin
               if (req_ch.byte_valid) begin
                  merged[{byte_pos_ff, 3'b000} +: 8] = req_ch.data_byte;
                  bit_len_in = bit_len_ff + 64'd8;
                  if (byte_pos_ff == LAST_BYTE) begin
                     wr.en       = 1'b1;
                     wr.data     = merged;
                     word_in     = '0;
                     byte_pos_in = 2'd0;
                     word_idx_in = word_idx_ff + 4'd1;
                     push        = (word_idx_ff == LAST_WORD);
                  end else begin
                     word_in     = merged;
                     byte_pos_in = byte_pos_ff + 2'd1;
                  end
               end
               if (req_ch.last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // Marker byte after the message; upper bytes are already zero
            if (slot_free) begin
               merged[{byte_pos_ff, 3'b000} +: 8] = PAD_BYTE;
               wr.en       = 1'b1;
               wr.data     = merged;
               word_in     = '0;
               byte_pos_in = 2'd0;
               word_idx_in = word_idx_ff + 4'd1;
               push        = (word_idx_ff == LAST_WORD);
               state_in    = ST_ZERO;
            end
         end
         ST_ZERO: begin
            // Zero fill up to the length field, spilling into a new block
            if (word_idx_ff == LEN_WORD_LO) begin
               state_in = ST_LEN_LO;
            end else if (slot_free) begin
               wr.en       = 1'b1;
               wr.data     = '0;
               word_idx_in = word_idx_ff + 4'd1;
               push        = (word_idx_ff == LAST_WORD);
            end
         end
         ST_LEN_LO: begin
            if (slot_free) begin
               wr.en       = 1'b1;
               wr.data     = bit_len_ff[31:0];
               word_idx_in = LEN_WORD_HI;
               state_in    = ST_LEN_HI;
            end
         end
         ST_LEN_HI: begin
            if (slot_free) begin
               wr.en       = 1'b1;
               wr.data     = bit_len_ff[63:32];
               word_idx_in = 4'd0;
               bit_len_in  = '0;
               push        = 1'b1;
               push_final  = 1'b1;
               state_in    = ST_BYTES;
            end
         end
         default: begin
            state_in = ST_BYTES;
         end
      endcase
   end

   // Queue bookkeeping
   always_comb begin
      wr_slot_in = wr_slot_ff;
      rd_slot_in = rd_slot_ff;
      final_in   = final_ff;
      if (push) begin
         final_in[wr_slot_ff] = push_final;
         wr_slot_in           = ~wr_slot_ff;
      end
      if (ack.done) begin
         rd_slot_in = ~rd_slot_ff;
      end
      count_in = count_ff + {1'b0, push} - {1'b0, ack.done};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_BYTES;
         word_ff     <= '0;
         byte_pos_ff <= 2'd0;
         word_idx_ff <= 4'd0;
         bit_len_ff  <= '0;
         wr_slot_ff  <= 1'b0;
         rd_slot_ff  <= 1'b0;
         count_ff    <= 2'd0;
         final_ff    <= 2'b00;
      end else begin
         state_ff    <= state_in;
         word_ff     <= word_in;
         byte_pos_ff <= byte_pos_in;
         word_idx_ff <= word_idx_in;
         bit_len_ff  <= bit_len_in;
         wr_slot_ff  <= wr_slot_in;
         rd_slot_ff  <= rd_slot_in;
         count_ff    <= count_in;
         final_ff    <= final_in;
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SLOTS)
      else $error("block queue occupancy exceeds slot count");

   a_write_free_slot: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (count_ff < SLOTS))
      else $error("block RAM write into a slot still queued");
`endif

endmodule

@@ rtl/core/md5s_back.sv @@
// ----------------------------------------------------------------------------
// md5s_back
// Compression core: one MD5 round per cycle over the head block of the
// queue, chaining update, and the digest output register.
// ----------------------------------------------------------------------------
module md5s_back (
   input  logic                          clock,
   input  logic                          reset,
   input  md5s_pkg::blk_desc_type        desc,
   output md5s_pkg::blk_ack_type         ack,
   output logic [md5s_pkg::RAM_ADDR_W-1:0] rd_addr,
   input  logic [31:0]                   rd_data,
   md5s_rsp_if.source                    rsp_ch
);
   import md5s_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_ROUND = 2'd1;
   localparam logic [1:0] ST_ADD   = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [5:0]  round_ff, round_in;
   logic [31:0] a_ff, a_in, b_ff, b_in, c_ff, c_in, d_ff, d_in;
   logic [31:0] cv_ff [4];
   logic [31:0] cv_in [4];
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] dig_ff [4];
   logic [31:0] dig_in [4];

   logic [5:0]  rd_round;
   logic [31:0] f_val;
   logic [31:0] pre_rot;
   logic [4:0]  rot_n;
   logic [31:0] rotated;
   logic [31:0] t_val;
   logic [31:0] sums [4];
   logic        out_free;

   // Read address runs one round ahead of the round logic
   assign rd_round = (state_ff == ST_ROUND) ? (round_ff + 6'd1) : 6'd0;
   assign rd_addr  = {desc.slot, msg_index(rd_round)};

   // Round function
   always_comb begin
      case (round_ff[5:4])
         2'd0: f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f_val = (b_ff & d_ff) | (c_ff & ~d_ff);
         2'd2: f_val = b_ff ^ c_ff ^ d_ff;
         2'd3: f_val = c_ff ^ (b_ff | ~d_ff);
         default: f_val = b_ff ^ c_ff ^ d_ff;
      endcase
   end

   assign pre_rot = a_ff + f_val + rd_data + ROUND_K[round_ff];
   assign rot_n   = ROT_AMT[{round_ff[5:4], round_ff[1:0]}];
   assign rotated = (pre_rot << rot_n) | (pre_rot >> (6'd32 - {1'b0, rot_n}));
   assign t_val   = b_ff + rotated;

   assign sums[0] = cv_ff[0] + a_ff;
   assign sums[1] = cv_ff[1] + b_ff;
   assign sums[2] = cv_ff[2] + c_ff;
   assign sums[3] = cv_ff[3] + d_ff;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.digest_word0 = dig_ff[0];
   assign rsp_ch.digest_word1 = dig_ff[1];
   assign rsp_ch.digest_word2 = dig_ff[2];
   assign rsp_ch.digest_word3 = dig_ff[3];

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      cv_in        = cv_ff;
      dig_in       = dig_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      ack.done     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (desc.avail) begin
               a_in     = cv_ff[0];
               b_in     = cv_ff[1];
               c_in     = cv_ff[2];
               d_in     = cv_ff[3];
               round_in = 6'd0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            a_in     = d_ff;
            d_in     = c_ff;
            c_in     = b_ff;
            b_in     = t_val;
            round_in = round_ff + 6'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (!desc.last_blk) begin
               cv_in    = sums;
               ack.done = 1'b1;
               state_in = ST_IDLE;
            end else if (out_free) begin
               // Final block: hand out digest, restart chaining
               dig_in       = sums;
               rsp_valid_in = 1'b1;
               cv_in        = INIT_CV;
               ack.done     = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and chaining state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= 6'd0;
         cv_ff        <= INIT_CV;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         cv_ff        <= cv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and output payload
   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      dig_ff <= dig_in;
   end

`ifndef SYNTH
   a_round_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && round_ff == LAST_ROUND) |=> (state_ff == ST_ADD))
      else $error("round 63 not followed by chaining add");

   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && !desc.avail) |=> (state_ff == ST_IDLE))
      else $error("compression started with empty block queue");

   a_digest_restart: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD && desc.last_blk && ack.done)
      |=> (rsp_valid_ff && cv_ff[0] == INIT_CV[0] && cv_ff[3] == INIT_CV[3]))
      else $error("digest not posted or chaining not restarted");
`endif

endmodule

@@ rtl/core/md5_digest_stream_top.sv @@
// Sequence: a byte is taken on each handshake with byte_valid set; a full block is
//   compressed by a start step, 64 rounds and a chaining add. After the last item,
//   padding takes up to 18 word writes, then one or two block compressions before
//   the digest is posted. The two-slot block queue lets byte intake run while the
//   previous block compresses.
// Reset: synchronous, active high; chaining words return to the MD5 initial values.
// ----------------------------------------------------------------------------
// md5_digest_stream_top
// Byte-serial MD5 digest engine: front end packs and pads, back end compresses.
// ----------------------------------------------------------------------------
module md5_digest_stream_top (
   input  logic        clock,
   input  logic        reset,
   md5s_req_if.sink    req_ch,
   md5s_rsp_if.source  rsp_ch
);
   import md5s_pkg::*;

   blk_desc_type           desc;
   blk_ack_type            ack;
   mem_wr_type             wr;
   logic [RAM_ADDR_W-1:0]  rd_addr;
   logic [31:0]            rd_data;

   // Byte intake, padding and block queue
   md5s_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .ack    (ack),
      .desc   (desc),
      .wr     (wr)
   );

   // Two block slots of message words
   md5s_ram #(
      .WIDTH (32),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Compression core and digest output
   md5s_back u_back (
      .clock   (clock),
      .reset   (reset),
      .desc    (desc),
      .ack     (ack),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .rsp_ch  (rsp_ch)
   );

endmodule
